@@ hdl/chxy_pkg.sv @@
// Shared types, widths and constants for the compass heading block.
package chxy_pkg;

    // Defaults for the top-level parameters
    localparam int DEF_CORDIC_STEPS    = 16;
    localparam int DEF_ANGLE_FRAC_BITS = 6;

    // Fixed-point layout of the rotation datapath
    localparam int DX_W     = 18;             // corrected axis value
    localparam int PRESCALE = 16;             // axis scaling before rotation
    localparam int XY_W     = DX_W + PRESCALE + 2;  // headroom for CORDIC gain
    localparam int ZFRAC    = 20;             // angle in 2^-20 degree
    localparam int Z_W      = 31;
    localparam int ATAN_LEN = 24;
    localparam int HEAD_W   = 15;

    localparam logic signed [Z_W-1:0] Z_HALF_TURN = Z_W'(180 * (2 ** ZFRAC));

    // atan(2^-i) in 2^-20 degree, rounded to nearest
    localparam logic signed [Z_W-1:0] ATAN_TAB [0:ATAN_LEN-1] = '{
        31'sd47185920, 31'sd27855475, 31'sd14718068, 31'sd7471121,
        31'sd3750058,  31'sd1876857,  31'sd938658,   31'sd469357,
        31'sd234682,   31'sd117342,   31'sd58671,    31'sd29335,
        31'sd14668,    31'sd7334,     31'sd3667,     31'sd1833,
        31'sd917,      31'sd458,      31'sd229,      31'sd115,
        31'sd57,       31'sd29,       31'sd14,       31'sd7
    };

    // Register map
    localparam int PADDR_W = 4;
    localparam logic [1:0] REG_X_OFFSET    = 2'd0;
    localparam logic [1:0] REG_Y_OFFSET    = 2'd1;
    localparam logic [1:0] REG_DECLINATION = 2'd2;
    localparam logic signed [14:0] DECL_RESET = -15'sd55;

    // Vector handed from cell to cell
    typedef struct packed {
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic signed [Z_W-1:0]  z;
        logic                   zero;
    } chxy_vec_t;

endpackage

@@ hdl/chxy_ifs.sv @@
// Valid/ready channel interfaces for magnetometer samples and headings.
interface chxy_sample_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] raw_x;
    logic signed [15:0] raw_y;

    modport source (output valid, output raw_x, output raw_y, input ready);
    modport sink   (input valid, input raw_x, input raw_y, output ready);
endinterface

interface chxy_heading_if;
    logic        valid;
    logic        ready;
    logic [14:0] heading;

    modport source (output valid, output heading, input ready);
    modport sink   (input valid, input heading, output ready);
endinterface

@@ hdl/chxy_prep.sv @@
// Front cell: offset removal, zero detect and left half-plane fold.
module chxy_prep
    import chxy_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic signed [12:0]     x_offset,
    input  logic signed [12:0]     y_offset,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic signed [15:0]     raw_x,
    input  logic signed [15:0]     raw_y,
    output logic                   out_valid,
    input  logic                   out_ready,
    output chxy_vec_t              out_data
);

    logic signed [DX_W-1:0] dx;
    logic signed [DX_W-1:0] dy;
    logic signed [DX_W-1:0] fx;
    logic signed [DX_W-1:0] fy;
    logic                   neg;
    chxy_vec_t              data_next;
    chxy_vec_t              data_reg;
    logic                   valid_reg;

    assign dx  = DX_W'(raw_x) - DX_W'(x_offset);
    assign dy  = DX_W'(raw_y) - DX_W'(y_offset);
    assign neg = dx[DX_W-1];
    assign fx  = neg ? -dx : dx;
    assign fy  = neg ? -dy : dy;

    always_comb
    begin
        data_next.x    = XY_W'(fx) <<< PRESCALE;
        data_next.y    = XY_W'(fy) <<< PRESCALE;
        data_next.z    = neg ? Z_HALF_TURN : '0;
        data_next.zero = (dx == '0) && (dy == '0);
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            data_reg <= data_next;
        end
    end

endmodule

@@ hdl/chxy_cell.sv @@
// One vectoring CORDIC micro-rotation cell with its own pipeline register.
module chxy_cell
    import chxy_pkg::*;
#(
    parameter int STAGE = 0
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  chxy_vec_t in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output chxy_vec_t out_data
);

    logic signed [XY_W-1:0] xs;
    logic signed [XY_W-1:0] ys;
    chxy_vec_t              data_next;
    chxy_vec_t              data_reg;
    logic                   valid_reg;

    assign xs = in_data.x >>> STAGE;
    assign ys = in_data.y >>> STAGE;

    // y == 0 rotates as if positive
    always_comb
    begin
        data_next.zero = in_data.zero;
        if (!in_data.y[XY_W-1])
        begin
            data_next.x = in_data.x + ys;
            data_next.y = in_data.y - xs;
            data_next.z = in_data.z + ATAN_TAB[STAGE];
        end
        else
        begin
            data_next.x = in_data.x - ys;
            data_next.y = in_data.y + xs;
            data_next.z = in_data.z - ATAN_TAB[STAGE];
        end
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            data_reg <= data_next;
        end
    end

endmodule

@@ hdl/chxy_post.sv @@
// Back cells: angle rounding and wrap, then declination add and 0..360 wrap.
module chxy_post
    import chxy_pkg::*;
#(
    parameter int ANGLE_FRAC_BITS = DEF_ANGLE_FRAC_BITS
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic signed [14:0]   declination,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  chxy_vec_t            in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [HEAD_W-1:0]    heading
);

    localparam int SH  = ZFRAC - ANGLE_FRAC_BITS;
    localparam int H_W = ANGLE_FRAC_BITS + 16;
    localparam logic signed [H_W-1:0] HALF = H_W'(180 * (2 ** ANGLE_FRAC_BITS));
    localparam logic signed [H_W-1:0] FULL = H_W'(360 * (2 ** ANGLE_FRAC_BITS));
    localparam logic signed [Z_W:0]   RND  = (Z_W+1)'(2 ** (SH - 1));

    logic signed [Z_W:0]   zr;
    logic signed [H_W-1:0] a_raw;
    logic signed [H_W-1:0] a_next;
    logic signed [H_W-1:0] a_reg;
    logic                  va_reg;
    logic                  b_ready;
    logic signed [H_W-1:0] d;
    logic signed [H_W-1:0] h0;
    logic signed [H_W-1:0] h1;
    logic signed [H_W-1:0] h_next;
    logic [HEAD_W-1:0]     heading_reg;
    logic                  vb_reg;

    // round half up to the output unit; zero vector gives angle 0
    assign zr    = (in_data.zero ? '0 : (Z_W+1)'(in_data.z)) + RND;
    assign a_raw = H_W'(zr >>> SH);

    always_comb
    begin
        a_next = a_raw;
        if (a_raw > HALF)
        begin
            a_next = a_raw - FULL;
        end
        else if (a_raw <= -HALF)
        begin
            a_next = a_raw + FULL;
        end
    end

    always_comb
    begin
        d = H_W'(declination);
        if (d > HALF)
        begin
            d = HALF;
        end
        else if (d < -HALF)
        begin
            d = -HALF;
        end
        h0 = a_reg + d;
        h1 = h0[H_W-1] ? h0 + FULL : h0;
        h_next = (h1 > FULL) ? h1 - FULL : h1;
    end

    assign b_ready   = !vb_reg || out_ready;
    assign in_ready  = !va_reg || b_ready;
    assign out_valid = vb_reg;
    assign heading   = heading_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                va_reg <= in_valid;
            end
            if (b_ready)
            begin
                vb_reg <= va_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            a_reg <= a_next;
        end
        if (va_reg && b_ready)
        begin
            heading_reg <= h_next[HEAD_W-1:0];
        end
    end

endmodule

@@ hdl/compass_heading_from_xy.sv @@
// Top level: compass heading from magnetometer X/Y through a CORDIC cell chain.
//
// Usage:
//   sample  - valid/ready sink; one item carries signed 16-bit raw_x, raw_y.
//   result  - valid/ready source; one item carries the 15-bit heading in
//             2^-ANGLE_FRAC_BITS degree units, 0 up to and including 360 deg.
//   APB     - x_offset (0x0), y_offset (0x4), declination (0x8); write only
//             while no item is in flight. Reads return the sign-extended value.
// The chain holds one offset/fold cell, one cell per micro-rotation, then a
// round/wrap cell and a declination cell. Throughput is one item per cycle
// while result.ready stays high; every cell holds one item and passes it
// on as soon as its neighbor has room, so the chain fills its bubbles.
// When the receiver stalls, items pile up cell by cell; sample.ready drops
// only once every cell is occupied.
// Reset empties the chain and loads offsets 0 and declination -55
// (-55/64 deg at the default scale).
module compass_heading_from_xy
    import chxy_pkg::*;
#(
    parameter int CORDIC_STEPS    = DEF_CORDIC_STEPS,
    parameter int ANGLE_FRAC_BITS = DEF_ANGLE_FRAC_BITS
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    chxy_sample_if.sink          sample,
    chxy_heading_if.source       result,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [PADDR_W-1:0]   paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);

    // configuration registers
    logic signed [12:0] x_offset_reg;
    logic signed [12:0] y_offset_reg;
    logic signed [14:0] declination_reg;
    logic               cfg_write;
    logic [1:0]         reg_sel;

    assign pready    = 1'b1;
    assign reg_sel   = paddr[3:2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_offset_reg    <= '0;
            y_offset_reg    <= '0;
            declination_reg <= DECL_RESET;
        end
        else if (cfg_write)
        begin
            unique case (reg_sel)
                REG_X_OFFSET:    x_offset_reg    <= pwdata[12:0];
                REG_Y_OFFSET:    y_offset_reg    <= pwdata[12:0];
                REG_DECLINATION: declination_reg <= pwdata[14:0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            REG_X_OFFSET:    prdata = 32'(x_offset_reg);
            REG_Y_OFFSET:    prdata = 32'(y_offset_reg);
            REG_DECLINATION: prdata = 32'(declination_reg);
            default:         prdata = '0;
        endcase
    end

    // cell chain: link k feeds micro-rotation k
    logic      link_valid [0:CORDIC_STEPS];
    logic      link_ready [0:CORDIC_STEPS];
    chxy_vec_t link_data  [0:CORDIC_STEPS];

    chxy_prep u_prep (
        .clk       (clk),
        .rst_n     (rst_n),
        .x_offset  (x_offset_reg),
        .y_offset  (y_offset_reg),
        .in_valid  (sample.valid),
        .in_ready  (sample.ready),
        .raw_x     (sample.raw_x),
        .raw_y     (sample.raw_y),
        .out_valid (link_valid[0]),
        .out_ready (link_ready[0]),
        .out_data  (link_data[0])
    );

    for (genvar k = 0; k < CORDIC_STEPS; k++)
    begin : g_cell
        chxy_cell #(
            .STAGE (k)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (link_valid[k]),
            .in_ready  (link_ready[k]),
            .in_data   (link_data[k]),
            .out_valid (link_valid[k+1]),
            .out_ready (link_ready[k+1]),
            .out_data  (link_data[k+1])
        );
    end

    chxy_post #(
        .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
    ) u_post (
        .clk         (clk),
        .rst_n       (rst_n),
        .declination (declination_reg),
        .in_valid    (link_valid[CORDIC_STEPS]),
        .in_ready    (link_ready[CORDIC_STEPS]),
        .in_data     (link_data[CORDIC_STEPS]),
        .out_valid   (result.valid),
        .out_ready   (result.ready),
        .heading     (result.heading)
    );

endmodule
